>>> src/slcd_pkg.sv
`timescale 1ns / 1ps
package slcd_pkg;

    localparam int unsigned EVENT_W = 3;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_SYNC     = 3'd1,
        EV_STORED   = 3'd2,
        EV_GOOD     = 3'd3,
        EV_BADSUM   = 3'd4,
        EV_OVERFLOW = 3'd5,
        EV_TIMEOUT  = 3'd6
    } t_event;

    localparam logic [7:0] CFG_SYNC_BYTE     = 8'd0;
    localparam logic [7:0] CFG_TIMEOUT_TICKS = 8'd1;

    localparam logic [7:0]  SYNC_BYTE_RESET     = 8'd170;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd3;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] data_byte;
        logic [7:0] store_index;
    } t_result;

    typedef struct packed {
        logic synced;
        logic have_length;
        logic frame_ready;
    } t_front_stat;

endpackage

>>> src/slcd_front.sv
`timescale 1ns / 1ps
module slcd_front import slcd_pkg::*; #(
    parameter int unsigned BUF_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_sync_byte,
    input  logic [15:0] i_timeout_ticks,
    output t_result     o_result,
    output t_front_stat o_stat
);

    logic        r_synced, n_synced;
    logic        r_have_length, n_have_length;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_idle, n_idle;
    logic        r_frame_ready, n_frame_ready;
    t_result     n_result;

    always_comb begin
        n_synced      = r_synced;
        n_have_length = r_have_length;
        n_remaining   = r_remaining;
        n_sum         = r_sum;
        n_count       = r_count;
        n_idle        = r_idle;
        n_frame_ready = r_frame_ready;
        n_result.event_res   = EV_NONE;
        n_result.data_byte   = 8'd0;
        n_result.store_index = 8'd0;
        if (i_func == FUNC_TICK) begin
            if (r_idle != 16'hFFFF) begin
                n_idle = r_idle + 16'd1;
            end
            if (r_synced && (n_idle > i_timeout_ticks)) begin
                n_synced      = 1'b0;
                n_have_length = 1'b0;
                n_result.event_res = EV_TIMEOUT;
            end
        end else begin
            n_idle = 16'd0;
            if (!r_synced) begin
                if (i_rx_byte == i_sync_byte) begin
                    n_synced      = 1'b1;
                    n_frame_ready = 1'b0;
                    n_result.event_res = EV_SYNC;
                end
            end else if (!r_have_length) begin
                n_have_length = 1'b1;
                n_sum         = i_rx_byte;
                n_remaining   = i_rx_byte - 8'd1;
                n_count       = 8'd0;
            end else begin
                n_sum       = r_sum + i_rx_byte;
                n_remaining = r_remaining - 8'd1;
                if (n_remaining == 8'd0) begin
                    n_synced      = 1'b0;
                    n_have_length = 1'b0;
                    if (n_sum == 8'd0) begin
                        n_frame_ready = 1'b1;
                        n_result.event_res = EV_GOOD;
                    end else begin
                        n_result.event_res = EV_BADSUM;
                    end
                end else if (r_count < 8'(BUF_DEPTH)) begin
                    n_count = r_count + 8'd1;
                    n_result.event_res = EV_STORED;
                    n_result.data_byte = i_rx_byte;
                end else begin
                    n_synced      = 1'b0;
                    n_have_length = 1'b0;
                    n_result.event_res = EV_OVERFLOW;
                end
            end
        end
        // A stored byte reports its buffer slot; every other event the count.
        if (n_result.event_res == EV_STORED) begin
            n_result.store_index = r_count;
        end else begin
            n_result.store_index = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced      <= 1'b0;
            r_have_length <= 1'b0;
            r_remaining   <= 8'd0;
            r_sum         <= 8'd0;
            r_count       <= 8'd0;
            r_idle        <= 16'd0;
            r_frame_ready <= 1'b0;
        end else if (i_accept) begin
            r_synced      <= n_synced;
            r_have_length <= n_have_length;
            r_remaining   <= n_remaining;
            r_sum         <= n_sum;
            r_count       <= n_count;
            r_idle        <= n_idle;
            r_frame_ready <= n_frame_ready;
        end
    end

    assign o_result           = n_result;
    assign o_stat.synced      = r_synced;
    assign o_stat.have_length = r_have_length;
    assign o_stat.frame_ready = r_frame_ready;

endmodule

>>> src/slcd_fifo.sv
`timescale 1ns / 1ps
module slcd_fifo import slcd_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_result        r_mem [DEPTH];
    logic [PTR_W:0] r_wr_ptr;
    logic [PTR_W:0] r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W]) &&
                     (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);
    assign o_data  = r_mem[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

>>> src/slcd_back.sv
`timescale 1ns / 1ps
module slcd_back import slcd_pkg::*; #(
    parameter int unsigned BUF_DEPTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_result i_data,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int unsigned ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0] r_payload_store [BUF_DEPTH];
    logic       r_valid;
    t_result    r_data;

    // A queued result reloads the output register if empty or drained.
    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_data.event_res == EV_STORED)) begin
            r_payload_store[i_data.store_index[ADDR_W-1:0]] <= i_data.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/sync_length_checksum_deframer_core.sv
`timescale 1ns / 1ps
// An accepted input writes its result into the result queue, which feeds the output
// register on the master side. Throughput: one item per cycle while the queue is not
// full; the four-entry queue plus the output register absorb master-side stalls.
// Reset: synchronous, active low; clears frame state, idle count, queue and output valid.
// The payload store holds no reset value and needs no clearing pass.
module sync_length_checksum_deframer_core import slcd_pkg::*; #(
    parameter int unsigned BUF_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] store_index
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [7:0]  r_sync_byte;
    logic [15:0] r_timeout_ticks;

    logic        s_accept;
    logic        fifo_full;
    logic        fifo_empty;
    logic        fifo_pop;
    t_result     front_result;
    t_result     fifo_data;
    t_result     out_data;
    t_front_stat front_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte     <= SYNC_BYTE_RESET;
            r_timeout_ticks <= TIMEOUT_TICKS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_BYTE:     r_sync_byte     <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !fifo_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    slcd_front #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (s_accept),
        .i_func         (s_axis_tuser),
        .i_rx_byte      (s_axis_tdata),
        .i_sync_byte    (r_sync_byte),
        .i_timeout_ticks(r_timeout_ticks),
        .o_result       (front_result),
        .o_stat         (front_stat)
    );

    slcd_fifo #(
        .DEPTH(4)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s_accept),
        .i_data (front_result),
        .o_full (fifo_full),
        .i_pop  (fifo_pop),
        .o_empty(fifo_empty),
        .o_data (fifo_data)
    );

    slcd_back #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(fifo_empty),
        .i_data (fifo_data),
        .o_pop  (fifo_pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (out_data)
    );

    assign m_axis_tdata = {out_data.store_index, out_data.data_byte};
    assign m_axis_tuser = out_data.event_res;

    // A length can only be pending inside an open frame.
    a_length_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.have_length |-> front_stat.synced)
        else $error("length held outside a frame");

    // A good frame is flagged only by an accepted byte.
    a_ready_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(front_stat.frame_ready) |->
            $past(s_accept) && ($past(s_axis_tuser) == FUNC_BYTE))
        else $error("frame ready set without a byte");

    // A stored byte always lands inside the payload buffer.
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_STORED)) |->
            (m_axis_tdata[15:8] < 8'(BUF_DEPTH)))
        else $error("store index beyond buffer");

    // The output holds no result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

>>> dv/tb_sync_length_checksum_deframer_core.sv
`timescale 1ns / 1ps
module tb_sync_length_checksum_deframer_core;
    import slcd_pkg::*;

    localparam int unsigned STORE_DEPTH  = 32;
    localparam int unsigned PHASE_ITEMS  = 60;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [7:0]  CFG_UNUSED_INDEX = 8'hFF;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_rx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = FUNC_BYTE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Receiver state as the block should hold it, plus its register copies.
    logic        in_frame = 1'b0;
    logic        got_length = 1'b0;
    logic [7:0]  remaining = '0;
    logic [7:0]  csum = '0;
    logic [7:0]  stored_count = '0;
    logic [15:0] idle_count = '0;
    logic [7:0]  sync_reg = SYNC_BYTE_RESET;
    logic [15:0] timeout_reg = TIMEOUT_TICKS_RESET;

    t_rx_item    rx_items_q[$];
    t_result     expected_events_q[$];
    t_rx_item    next_item;
    t_result     want_res;
    t_result     got_res;
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    sync_length_checksum_deframer_core #(
        .BUF_DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result deframe_step(input logic func, input logic [7:0] b);
        t_result r;
        r = '0;
        r.event_res = EV_NONE;
        if (func == FUNC_TICK) begin
            if (idle_count != 16'hFFFF) idle_count = idle_count + 16'd1;
            if (in_frame && idle_count > timeout_reg) begin
                in_frame = 1'b0;
                got_length = 1'b0;
                r.event_res = EV_TIMEOUT;
            end
        end else begin
            idle_count = '0;
            if (!in_frame) begin
                if (b == sync_reg) begin
                    in_frame = 1'b1;
                    r.event_res = EV_SYNC;
                end
            end else if (!got_length) begin
                // The length byte seeds the sum and is neither stored nor checked.
                got_length = 1'b1;
                csum = b;
                remaining = b - 8'd1;
                stored_count = '0;
            end else begin
                csum = csum + b;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0) begin
                    in_frame = 1'b0;
                    got_length = 1'b0;
                    r.event_res = (csum == 8'd0) ? EV_GOOD : EV_BADSUM;
                end else if (stored_count < STORE_DEPTH) begin
                    r.event_res = EV_STORED;
                    r.data_byte = b;
                    r.store_index = stored_count;
                    stored_count = stored_count + 8'd1;
                end else begin
                    in_frame = 1'b0;
                    got_length = 1'b0;
                    r.event_res = EV_OVERFLOW;
                end
            end
        end
        if (r.event_res != EV_STORED) r.store_index = stored_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_events_q.push_back(deframe_step(s_axis_tuser, s_axis_tdata));
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (rx_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = rx_items_q.pop_front();
                    s_axis_tuser  <= next_item.func;
                    s_axis_tdata  <= next_item.rx_byte;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res.event_res   = t_event'(m_axis_tuser);
                got_res.data_byte   = m_axis_tdata[7:0];
                got_res.store_index = m_axis_tdata[15:8];
                if (expected_events_q.size() == 0) begin
                    $display("%0t: unexpected result: event %0d data %02h index %0d",
                             $time, got_res.event_res, got_res.data_byte,
                             got_res.store_index);
                    n_errors++;
                end else begin
                    want_res = expected_events_q.pop_front();
                    if (got_res.event_res != want_res.event_res) begin
                        $display("%0t: event_res expected %0d actual %0d",
                                 $time, want_res.event_res, got_res.event_res);
                        n_errors++;
                    end
                    if (got_res.data_byte != want_res.data_byte) begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want_res.data_byte, got_res.data_byte);
                        n_errors++;
                    end
                    if (got_res.store_index != want_res.store_index) begin
                        $display("%0t: store_index expected %0d actual %0d",
                                 $time, want_res.store_index, got_res.store_index);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input logic func, input logic [7:0] b);
        t_rx_item it;
        it.func = func;
        it.rx_byte = b;
        rx_items_q.push_back(it);
        n_queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(FUNC_BYTE, b);
    endtask

    // Tick items carry a random byte that the block must ignore.
    task automatic push_ticks(input int unsigned count);
        repeat (count) push_item(FUNC_TICK, 8'($urandom));
    endtask

    // Occasional idle gap; long enough now and then to let an open frame time out.
    task automatic push_gap();
        int unsigned span;
        if ($urandom_range(0, 99) < 15) begin
            span = (timeout_reg < 16'd4) ? int'(timeout_reg) : 4;
            push_ticks($urandom_range(1, span + 2));
        end
    endtask

    task automatic add_traffic(input int unsigned budget);
        int unsigned start_cnt;
        int unsigned pick;
        int unsigned n_after;
        int unsigned n_emit;
        logic [7:0]  len;
        logic [7:0]  sum;
        logic [7:0]  b;
        start_cnt = n_queued;
        while (n_queued - start_cnt < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                if ($urandom_range(0, 1) == 1) push_byte(8'($urandom));
                else push_ticks($urandom_range(1, 3));
            end else begin
                push_byte(sync_reg);
                push_gap();
                pick = $urandom_range(0, 99);
                if (pick < 70) len = 8'($urandom_range(2, 14));
                else if (pick < 80) len = 8'($urandom_range(0, 1));
                else if (pick < 90) len = 8'($urandom_range(30, 40));
                else len = 8'($urandom_range(41, 255));
                push_byte(len);
                push_gap();
                sum = len;
                // A length of one wraps the count, so the frame runs 256 more bytes.
                n_after = (len == 8'd1) ? 256 : int'(8'(len - 8'd1));
                // Past a full buffer the next payload byte aborts, so stop there.
                n_emit = (n_after > STORE_DEPTH + 1) ? STORE_DEPTH + 1 : n_after;
                if ($urandom_range(0, 9) == 0) n_emit = $urandom_range(0, n_emit - 1);
                for (int unsigned k = 0; k < n_emit; k++) begin
                    if (k == n_after - 1 && $urandom_range(0, 3) != 0) b = 8'd0 - sum;
                    else b = 8'($urandom);
                    sum = sum + b;
                    push_byte(b);
                    push_gap();
                end
            end
        end
    endtask

    task automatic wait_quiet();
        while (n_accepted != n_queued || expected_events_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SYNC_BYTE) sync_reg = val[7:0];
        else if (idx == CFG_TIMEOUT_TICKS) timeout_reg = val;
    endtask

    task automatic run_phase(input t_idle_mode mode, input logic [7:0] sync_val,
                             input logic [15:0] tmo_val);
        wait_quiet();
        write_reg(CFG_SYNC_BYTE, 16'(sync_val));
        write_reg(CFG_TIMEOUT_TICKS, tmo_val);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 65;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = 65;
            end
            default: begin
                send_idle_pct = 17;
                recv_stall_pct = 17;
            end
        endcase
        add_traffic(PHASE_ITEMS);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the register values from reset.
        push_ticks(1);
        push_byte(8'h00);
        push_byte(8'hFF);
        // Good frame with one payload byte.
        push_byte(SYNC_BYTE_RESET);
        push_byte(8'd3);
        push_byte(8'h10);
        push_byte(8'hED);
        // Two-byte frame with a bad checksum.
        push_byte(SYNC_BYTE_RESET);
        push_byte(8'd2);
        push_byte(8'h05);
        // Length one wraps the count; the open frame then times out.
        push_byte(SYNC_BYTE_RESET);
        push_byte(8'd1);
        push_byte(8'hFF);
        push_ticks(4);
        // Length zero; a byte between tick runs clears the idle count.
        push_byte(SYNC_BYTE_RESET);
        push_byte(8'd0);
        push_byte(8'h7F);
        push_ticks(3);
        push_byte(8'h80);
        push_ticks(4);

        run_phase(IDLE_SENDER, 8'h00, 16'd0);
        run_phase(IDLE_RECEIVER, 8'hFF, 16'hFFFF);
        wait_quiet();
        write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        run_phase(IDLE_BOTH, 8'($urandom), 16'd2);
        run_phase(IDLE_NONE, 8'($urandom), 16'($urandom_range(0, 5)));
        run_phase(IDLE_SENDER, 8'h55, 16'd1);
        run_phase(IDLE_RECEIVER, 8'($urandom), 16'd3);
        run_phase(IDLE_BOTH, 8'hAA, 16'd4);
        wait_quiet();

        if (n_errors == 0) begin
            $display("tb_sync_length_checksum_deframer_core: clean");
        end else begin
            $display("tb_sync_length_checksum_deframer_core: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_sync_length_checksum_deframer_core: errors");
        $finish;
    end

endmodule

>>> sync_length_checksum_deframer_core.f
src/slcd_pkg.sv
src/slcd_front.sv
src/slcd_fifo.sv
src/slcd_back.sv
src/sync_length_checksum_deframer_core.sv
dv/tb_sync_length_checksum_deframer_core.sv
